FILE: hdl/i2cm_pkg.sv
// Shared types and codes for the I2C master bit engine.
// No dependencies; imported by i2cm_core and i2c_master_bit_engine.
package i2cm_pkg;

    // item kinds
    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_STOP     = 3'd2;
    localparam logic [2:0] KIND_WRITE    = 3'd3;
    localparam logic [2:0] KIND_RD_ACK   = 3'd4;
    localparam logic [2:0] KIND_RD_NACK  = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_BUS_BUSY    = 2'd1;
    localparam logic [1:0] STAT_START_FAIL  = 2'd2;
    localparam logic [1:0] STAT_ACK_TIMEOUT = 2'd3;

    // configuration register indexes
    localparam logic [7:0] CFG_PHASE_TICKS    = 8'd0;
    localparam logic [7:0] CFG_ACK_POLL_LIMIT = 8'd1;

    localparam logic [7:0] PHASE_TICKS_RST    = 8'd5;
    localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd255;

    // one result beat
    typedef struct packed {
        logic       scl_high;
        logic       sda_drive_enable;
        logic       sda_level;
        logic [7:0] rx_byte;
        logic       ack_received;
        logic       done_res;
        logic [1:0] status;
    } i2cm_res_t;

endpackage

FILE: hdl/i2cm_core.sv
// Bus sequencer: state registers plus the single-pass next-state logic.
// Depends on i2cm_pkg.
module i2cm_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [2:0]          kind,
    input  logic [7:0]          tx_byte,
    input  logic                sda_sample,
    input  logic [7:0]          phase_ticks,
    input  logic [7:0]          ack_poll_limit,
    output i2cm_pkg::i2cm_res_t res
);
    import i2cm_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_STA_A  = 5'd1;
    localparam logic [4:0] ST_STA_B  = 5'd2;
    localparam logic [4:0] ST_STA_C1 = 5'd3;
    localparam logic [4:0] ST_STA_C2 = 5'd4;
    localparam logic [4:0] ST_STA_D  = 5'd5;
    localparam logic [4:0] ST_STO_A  = 5'd6;
    localparam logic [4:0] ST_STO_B  = 5'd7;
    localparam logic [4:0] ST_WR_LO  = 5'd8;
    localparam logic [4:0] ST_WR_HI  = 5'd9;
    localparam logic [4:0] ST_AK_LO  = 5'd10;
    localparam logic [4:0] ST_AK_POL = 5'd11;
    localparam logic [4:0] ST_AK_TL  = 5'd12;
    localparam logic [4:0] ST_RD_LO  = 5'd13;
    localparam logic [4:0] ST_RD_HI  = 5'd14;
    localparam logic [4:0] ST_KA_LO  = 5'd15;
    localparam logic [4:0] ST_KA_HI  = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [7:0] phase_reg, phase_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] poll_reg, poll_next;
    logic       ack_mode_reg, ack_mode_next;
    logic       scl_reg, scl_next;
    logic       en_reg, en_next;
    logic       lvl_reg, lvl_next;
    logic [7:0] rx_reg, rx_next;
    logic       ack_reg, ack_next;
    logic       done;
    logic [1:0] stat;

    logic [7:0] p_eff, lim_eff, phase_inc, poll_inc;
    logic       pover;
    logic [3:0] bit_inc;
    logic [7:0] shl_wr, shl_rd;

    always_comb begin
        p_eff     = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
        lim_eff   = (ack_poll_limit == 8'd0) ? 8'd1 : ack_poll_limit;
        phase_inc = phase_reg + 8'd1;
        pover     = (phase_inc >= p_eff);
        poll_inc  = poll_reg + 8'd1;
        bit_inc   = bit_reg + 4'd1;
        shl_wr    = {shift_reg[6:0], 1'b0};
        shl_rd    = {shift_reg[6:0], sda_sample};

        state_next    = state_reg;
        phase_next    = phase_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        poll_next     = poll_reg;
        ack_mode_next = ack_mode_reg;
        scl_next      = scl_reg;
        en_next       = en_reg;
        lvl_next      = lvl_reg;
        rx_next       = rx_reg;
        ack_next      = ack_reg;
        done          = 1'b0;
        stat          = STAT_OK;

        if (kind == KIND_TICK) begin
            // phase states but AK_POL count; the counter is zero when the phase ends
            phase_next = pover ? 8'd0 : phase_inc;
            unique case (state_reg)
                ST_STA_A: begin
                    if (pover) begin
                        en_next    = 1'b0;
                        state_next = ST_STA_B;
                    end
                end
                ST_STA_B: begin
                    if (pover) begin
                        if (!sda_sample) begin
                            done       = 1'b1;
                            stat       = STAT_BUS_BUSY;
                            state_next = ST_IDLE;
                        end else begin
                            en_next    = 1'b1;
                            lvl_next   = 1'b0;
                            state_next = ST_STA_C1;
                        end
                    end
                end
                ST_STA_C1: begin
                    if (pover) state_next = ST_STA_C2;
                end
                ST_STA_C2: begin
                    if (pover) begin
                        if (sda_sample) begin
                            en_next    = 1'b0;
                            lvl_next   = 1'b1;
                            done       = 1'b1;
                            stat       = STAT_START_FAIL;
                            state_next = ST_IDLE;
                        end else begin
                            scl_next   = 1'b0;
                            state_next = ST_STA_D;
                        end
                    end
                end
                ST_STA_D: begin
                    if (pover) begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                ST_STO_A: begin
                    if (pover) begin
                        scl_next   = 1'b1;
                        state_next = ST_STO_B;
                    end
                end
                ST_STO_B: begin
                    if (pover) begin
                        lvl_next   = 1'b1;
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                ST_WR_LO: begin
                    if (pover) begin
                        scl_next   = 1'b1;
                        state_next = ST_WR_HI;
                    end
                end
                ST_WR_HI: begin
                    if (pover) begin
                        shift_next = shl_wr;
                        bit_next   = bit_inc;
                        scl_next   = 1'b0;
                        if (bit_inc >= 4'd8) begin
                            en_next    = 1'b0;
                            state_next = ST_AK_LO;
                        end else begin
                            lvl_next   = shl_wr[7];
                            state_next = ST_WR_LO;
                        end
                    end
                end
                ST_AK_LO: begin
                    if (pover) begin
                        scl_next   = 1'b1;
                        poll_next  = 8'd0;
                        state_next = ST_AK_POL;
                    end
                end
                ST_AK_POL: begin
                    // polled every tick, no phase counting here
                    phase_next = 8'd0;
                    if (!sda_sample) begin
                        ack_next   = 1'b1;
                        scl_next   = 1'b0;
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        poll_next = poll_inc;
                        if (poll_inc >= lim_eff) state_next = ST_AK_TL;
                    end
                end
                ST_AK_TL: begin
                    if (pover) begin
                        ack_next   = 1'b0;
                        scl_next   = 1'b0;
                        done       = 1'b1;
                        stat       = STAT_ACK_TIMEOUT;
                        state_next = ST_IDLE;
                    end
                end
                ST_RD_LO: begin
                    if (pover) begin
                        scl_next   = 1'b1;
                        state_next = ST_RD_HI;
                    end
                end
                ST_RD_HI: begin
                    if (pover) begin
                        shift_next = shl_rd;
                        bit_next   = bit_inc;
                        scl_next   = 1'b0;
                        if (bit_inc >= 4'd8) begin
                            rx_next    = shl_rd;
                            en_next    = 1'b1;
                            lvl_next   = !ack_mode_reg;
                            state_next = ST_KA_LO;
                        end else begin
                            state_next = ST_RD_LO;
                        end
                    end
                end
                ST_KA_LO: begin
                    if (pover) begin
                        scl_next   = 1'b1;
                        state_next = ST_KA_HI;
                    end
                end
                ST_KA_HI: begin
                    if (pover) begin
                        scl_next   = 1'b0;
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                default: begin
                    // idle tick: nothing moves
                    phase_next = phase_reg;
                    state_next = ST_IDLE;
                end
            endcase
        end else if (state_reg == ST_IDLE && kind <= KIND_RD_NACK) begin
            phase_next = 8'd0;
            bit_next   = 4'd0;
            poll_next  = 8'd0;
            unique case (kind)
                KIND_START: begin
                    scl_next   = 1'b1;
                    en_next    = 1'b1;
                    lvl_next   = 1'b1;
                    state_next = ST_STA_A;
                end
                KIND_STOP: begin
                    scl_next   = 1'b0;
                    en_next    = 1'b1;
                    lvl_next   = 1'b0;
                    state_next = ST_STO_A;
                end
                KIND_WRITE: begin
                    shift_next = tx_byte;
                    scl_next   = 1'b0;
                    en_next    = 1'b1;
                    lvl_next   = tx_byte[7];
                    state_next = ST_WR_LO;
                end
                default: begin
                    shift_next    = 8'd0;
                    ack_mode_next = (kind == KIND_RD_ACK);
                    scl_next      = 1'b0;
                    en_next       = 1'b0;
                    state_next    = ST_RD_LO;
                end
            endcase
        end

        res.scl_high         = scl_next;
        res.sda_drive_enable = en_next;
        res.sda_level        = lvl_next;
        res.rx_byte          = rx_next;
        res.ack_received     = ack_next;
        res.done_res         = done;
        res.status           = stat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= 8'd0;
            bit_reg      <= 4'd0;
            shift_reg    <= 8'd0;
            poll_reg     <= 8'd0;
            ack_mode_reg <= 1'b0;
            scl_reg      <= 1'b1;
            en_reg       <= 1'b0;
            lvl_reg      <= 1'b1;
            rx_reg       <= 8'd0;
            ack_reg      <= 1'b0;
        end else if (step) begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            poll_reg     <= poll_next;
            ack_mode_reg <= ack_mode_next;
            scl_reg      <= scl_next;
            en_reg       <= en_next;
            lvl_reg      <= lvl_next;
            rx_reg       <= rx_next;
            ack_reg      <= ack_next;
        end
    end

endmodule

FILE: hdl/i2c_master_bit_engine.sv
// I2C master bit engine top: input register, sequencer, result register.
// Its single-pass sequencer update is the only step between the two registers.
// Throughput: one item per cycle while m_ready does not stall the result register.
// Reset (aresetn low, synchronous): sequencer idle, SCL high, SDA released at 1,
//   phase_ticks 5, ack_poll_limit 255, both beat registers empty.
// Depends on i2cm_pkg and i2cm_core.
module i2c_master_bit_engine (
    input  logic       aclk,
    input  logic       aresetn,
    // item channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_kind,
    input  logic [7:0] s_tx_byte,
    input  logic       s_sda_sample,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_high,
    output logic       m_sda_drive_enable,
    output logic       m_sda_level,
    output logic [7:0] m_rx_byte,
    output logic       m_ack_received,
    output logic       m_done_res,
    output logic [1:0] m_status,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import i2cm_pkg::*;

    // configuration registers
    logic [7:0] phase_ticks_reg;
    logic [7:0] ack_poll_limit_reg;

    // input beat register
    logic       in_vld_reg;
    logic [2:0] in_kind_reg;
    logic [7:0] in_tx_reg;
    logic       in_sda_reg;

    // result beat register
    logic       out_vld_reg;
    i2cm_res_t  out_res_reg;
    i2cm_res_t  core_res;

    logic       advance;

    // the held beat moves on when the result slot is empty or being drained
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg    <= PHASE_TICKS_RST;
            ack_poll_limit_reg <= ACK_POLL_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PHASE_TICKS:    phase_ticks_reg    <= cfg_data;
                CFG_ACK_POLL_LIMIT: ack_poll_limit_reg <= cfg_data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_tx_reg   <= s_tx_byte;
            in_sda_reg  <= s_sda_sample;
        end
    end

    // sequencer state commits only when its result is captured
    i2cm_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .kind           (in_kind_reg),
        .tx_byte        (in_tx_reg),
        .sda_sample     (in_sda_reg),
        .phase_ticks    (phase_ticks_reg),
        .ack_poll_limit (ack_poll_limit_reg),
        .res            (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_scl_high         = out_res_reg.scl_high;
    assign m_sda_drive_enable = out_res_reg.sda_drive_enable;
    assign m_sda_level        = out_res_reg.sda_level;
    assign m_rx_byte          = out_res_reg.rx_byte;
    assign m_ack_received     = out_res_reg.ack_received;
    assign m_done_res         = out_res_reg.done_res;
    assign m_status           = out_res_reg.status;

endmodule

FILE: sim/tb_i2c_master_bit_engine.sv
// Self-checking testbench for i2c_master_bit_engine: command and tick beats in,
// bus state beats out, each checked against a cycle-free model of the sequencer.
// Depends on hdl/i2cm_pkg.sv and the engine RTL.
`timescale 1ns / 100ps

import i2cm_pkg::*;

// kinds the engine must drop
localparam logic [2:0] KIND_RSVD6 = 3'd6;
localparam logic [2:0] KIND_RSVD7 = 3'd7;

typedef enum logic [4:0] {
    SQ_IDLE, SQ_STA_A, SQ_STA_B, SQ_STA_C1, SQ_STA_C2, SQ_STA_D,
    SQ_STO_A, SQ_STO_B, SQ_WR_LO, SQ_WR_HI, SQ_AK_LO, SQ_AK_POL,
    SQ_AK_TL, SQ_RD_LO, SQ_RD_HI, SQ_KA_LO, SQ_KA_HI
} seq_phase_t;

class bus_scoreboard;
    logic [7:0] phase_ticks;
    logic [7:0] poll_limit;
    seq_phase_t st;
    logic [7:0] ph_cnt;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [7:0] poll_cnt;
    logic       ack_mode;
    logic       scl, en, lvl, ack;
    logic [7:0] rx;
    i2cm_res_t  beats_due[$];
    int         errors;
    int         checked;

    function new();
        phase_ticks = PHASE_TICKS_RST;
        poll_limit  = ACK_POLL_LIMIT_RST;
        st       = SQ_IDLE;
        ph_cnt   = 8'd0;
        bit_cnt  = 4'd0;
        shreg    = 8'd0;
        poll_cnt = 8'd0;
        ack_mode = 1'b0;
        scl      = 1'b1;
        en       = 1'b0;
        lvl      = 1'b1;
        ack      = 1'b0;
        rx       = 8'd0;
        errors   = 0;
        checked  = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] val);
        if (idx == CFG_PHASE_TICKS)
            phase_ticks = val;
        else if (idx == CFG_ACK_POLL_LIMIT)
            poll_limit = val;
    endfunction

    function bit is_idle();
        return st == SQ_IDLE;
    endfunction

    function void enter(seq_phase_t s);
        st     = s;
        ph_cnt = 8'd0;
    endfunction

    // zero ticks per phase behaves as one
    function bit phase_done();
        logic [7:0] p;
        p = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
        ph_cnt = ph_cnt + 8'd1;
        if (ph_cnt >= p) begin
            ph_cnt = 8'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void bus_tick(input logic sda, output logic done, output logic [1:0] stat);
        logic [7:0] lim;
        lim  = (poll_limit == 8'd0) ? 8'd1 : poll_limit;
        done = 1'b0;
        stat = STAT_OK;
        unique case (st)
            SQ_STA_A: if (phase_done()) begin
                en = 1'b0;
                enter(SQ_STA_B);
            end
            SQ_STA_B: if (phase_done()) begin
                if (!sda) begin
                    done = 1'b1;
                    stat = STAT_BUS_BUSY;
                    enter(SQ_IDLE);
                end else begin
                    en  = 1'b1;
                    lvl = 1'b0;
                    enter(SQ_STA_C1);
                end
            end
            SQ_STA_C1: if (phase_done()) enter(SQ_STA_C2);
            SQ_STA_C2: if (phase_done()) begin
                if (sda) begin
                    en   = 1'b0;
                    lvl  = 1'b1;
                    done = 1'b1;
                    stat = STAT_START_FAIL;
                    enter(SQ_IDLE);
                end else begin
                    scl = 1'b0;
                    enter(SQ_STA_D);
                end
            end
            SQ_STA_D: if (phase_done()) begin
                done = 1'b1;
                enter(SQ_IDLE);
            end
            SQ_STO_A: if (phase_done()) begin
                scl = 1'b1;
                enter(SQ_STO_B);
            end
            SQ_STO_B: if (phase_done()) begin
                lvl  = 1'b1;
                done = 1'b1;
                enter(SQ_IDLE);
            end
            SQ_WR_LO: if (phase_done()) begin
                scl = 1'b1;
                enter(SQ_WR_HI);
            end
            SQ_WR_HI: if (phase_done()) begin
                shreg   = shreg << 1;
                bit_cnt = bit_cnt + 4'd1;
                scl     = 1'b0;
                if (bit_cnt >= 4'd8) begin
                    en = 1'b0;
                    enter(SQ_AK_LO);
                end else begin
                    lvl = shreg[7];
                    enter(SQ_WR_LO);
                end
            end
            SQ_AK_LO: if (phase_done()) begin
                scl      = 1'b1;
                poll_cnt = 8'd0;
                enter(SQ_AK_POL);
            end
            SQ_AK_POL: begin
                if (!sda) begin
                    ack  = 1'b1;
                    scl  = 1'b0;
                    done = 1'b1;
                    enter(SQ_IDLE);
                end else begin
                    poll_cnt = poll_cnt + 8'd1;
                    if (poll_cnt >= lim)
                        enter(SQ_AK_TL);
                end
            end
            SQ_AK_TL: if (phase_done()) begin
                ack  = 1'b0;
                scl  = 1'b0;
                done = 1'b1;
                stat = STAT_ACK_TIMEOUT;
                enter(SQ_IDLE);
            end
            SQ_RD_LO: if (phase_done()) begin
                scl = 1'b1;
                enter(SQ_RD_HI);
            end
            SQ_RD_HI: if (phase_done()) begin
                shreg   = {shreg[6:0], sda};
                bit_cnt = bit_cnt + 4'd1;
                scl     = 1'b0;
                if (bit_cnt >= 4'd8) begin
                    rx  = shreg;
                    en  = 1'b1;
                    lvl = ack_mode ? 1'b0 : 1'b1;
                    enter(SQ_KA_LO);
                end else begin
                    enter(SQ_RD_LO);
                end
            end
            SQ_KA_LO: if (phase_done()) begin
                scl = 1'b1;
                enter(SQ_KA_HI);
            end
            SQ_KA_HI: if (phase_done()) begin
                scl  = 1'b0;
                done = 1'b1;
                enter(SQ_IDLE);
            end
            default: st = SQ_IDLE;
        endcase
    endfunction

    // advance the model by one accepted beat and queue the beat it causes
    function void note_item(logic [2:0] kind, logic [7:0] txb, logic sda);
        i2cm_res_t  r;
        logic       done;
        logic [1:0] stat;
        done = 1'b0;
        stat = STAT_OK;
        if (kind == KIND_TICK) begin
            bus_tick(sda, done, stat);
        end else if (st == SQ_IDLE && kind <= KIND_RD_NACK) begin
            ph_cnt   = 8'd0;
            bit_cnt  = 4'd0;
            poll_cnt = 8'd0;
            unique case (kind)
                KIND_START: begin
                    scl = 1'b1;
                    en  = 1'b1;
                    lvl = 1'b1;
                    enter(SQ_STA_A);
                end
                KIND_STOP: begin
                    scl = 1'b0;
                    en  = 1'b1;
                    lvl = 1'b0;
                    enter(SQ_STO_A);
                end
                KIND_WRITE: begin
                    shreg = txb;
                    scl   = 1'b0;
                    en    = 1'b1;
                    lvl   = txb[7];
                    enter(SQ_WR_LO);
                end
                default: begin
                    shreg    = 8'd0;
                    ack_mode = (kind == KIND_RD_ACK);
                    scl      = 1'b0;
                    en       = 1'b0;
                    enter(SQ_RD_LO);
                end
            endcase
        end
        r.scl_high         = scl;
        r.sda_drive_enable = en;
        r.sda_level        = lvl;
        r.rx_byte          = rx;
        r.ack_received     = ack;
        r.done_res         = done;
        r.status           = stat;
        beats_due.push_back(r);
    endfunction

    function void check_beat(i2cm_res_t got);
        i2cm_res_t want;
        checked++;
        if (beats_due.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("beat %0d: no beat due", checked);
                $display("  got scl=%b en=%b lvl=%b rx=%02h ack=%b done=%b st=%0d",
                         got.scl_high, got.sda_drive_enable, got.sda_level,
                         got.rx_byte, got.ack_received, got.done_res, got.status);
            end
            return;
        end
        want = beats_due.pop_front();
        if (got.scl_high !== want.scl_high || got.sda_drive_enable !== want.sda_drive_enable ||
            got.sda_level !== want.sda_level || got.rx_byte !== want.rx_byte ||
            got.ack_received !== want.ack_received || got.done_res !== want.done_res ||
            got.status !== want.status) begin
            errors++;
            if (errors <= 10) begin
                $display("beat %0d mismatch:", checked);
                $display("  exp scl=%b en=%b lvl=%b rx=%02h ack=%b done=%b st=%0d",
                         want.scl_high, want.sda_drive_enable, want.sda_level,
                         want.rx_byte, want.ack_received, want.done_res, want.status);
                $display("  got scl=%b en=%b lvl=%b rx=%02h ack=%b done=%b st=%0d",
                         got.scl_high, got.sda_drive_enable, got.sda_level,
                         got.rx_byte, got.ack_received, got.done_res, got.status);
            end
        end
    endfunction

    function void flush_check();
        if (beats_due.size() != 0) begin
            $display("%0d result beats never arrived", beats_due.size());
            errors += beats_due.size();
        end
    endfunction
endclass

module tb_i2c_master_bit_engine;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_kind;
    logic [7:0] s_tx_byte;
    logic       s_sda_sample;
    logic       m_valid;
    logic       m_ready;
    logic       m_scl_high;
    logic       m_sda_drive_enable;
    logic       m_sda_level;
    logic [7:0] m_rx_byte;
    logic       m_ack_received;
    logic       m_done_res;
    logic [1:0] m_status;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    i2cm_res_t     got_beat;
    bus_scoreboard sb;

    // gap / stall enables, both dropped for the closing stretch
    bit src_gaps    = 1'b1;
    bit sink_stalls = 1'b1;

    // beats that moved the engine (ignored commands and idle ticks excluded)
    int work_items = 0;

    // how the emulated slave and bus behave for the current command
    bit         sc_busy_fault;   // SDA held low by someone else before start
    bit         sc_start_fault;  // SDA stuck high while start drives it low
    int         sc_ack_delay;    // polls before the slave pulls ACK low
    logic [7:0] sc_slave_byte;   // byte the slave returns on a read

    i2c_master_bit_engine dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_tx_byte          (s_tx_byte),
        .s_sda_sample       (s_sda_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_scl_high         (m_scl_high),
        .m_sda_drive_enable (m_sda_drive_enable),
        .m_sda_level        (m_sda_level),
        .m_rx_byte          (m_rx_byte),
        .m_ack_received     (m_ack_received),
        .m_done_res         (m_done_res),
        .m_status           (m_status),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    assign got_beat = {m_scl_high, m_sda_drive_enable, m_sda_level, m_rx_byte,
                       m_ack_received, m_done_res, m_status};

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop in case a handshake hangs
    initial begin : watchdog
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stall bursts, long runs with ready held high
    initial begin : sink
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_stalls && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    // Result monitor. Values read here are the ones the edge itself sampled,
    // since every driver in the bench and the RTL updates with NBAs.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_beat(got_beat);
    end

    // SDA as the wire would show it on the next tick, from the model's view of
    // where the engine is; the fault flags bend it into the error paths.
    function automatic logic bus_sda();
        logic v;
        case (sb.st)
            SQ_STA_B:  v = sc_busy_fault ? 1'b0 : 1'b1;
            SQ_STA_C2: v = sc_start_fault ? 1'b1 : 1'b0;
            SQ_AK_POL: v = (int'(sb.poll_cnt) >= sc_ack_delay) ? 1'b0 : 1'b1;
            SQ_RD_HI:  v = sc_slave_byte[3'd7 - sb.bit_cnt[2:0]];
            default:   v = sb.en ? sb.lvl : 1'b1;
        endcase
        return v;
    endfunction

    function automatic void set_scenario(bit busy, bit stfail, int delay, logic [7:0] slave);
        sc_busy_fault  = busy;
        sc_start_fault = stfail;
        sc_ack_delay   = delay;
        sc_slave_byte  = slave;
    endfunction

    // One beat on the item channel. Valid is only dropped when a gap is
    // taken, so back-to-back beats keep it high across the edge.
    task automatic send_item(input logic [2:0] kind, input logic [7:0] txb, input logic sda);
        if (src_gaps && $urandom_range(0, 11) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_tx_byte    <= txb;
        s_sda_sample <= sda;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(kind, txb, sda);
    endtask

    // Hold the sender off until every queued result beat is back.
    // Always waits for a clock edge so valid never drops and rises in one step.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.beats_due.size() != 0);
    endtask

    // Both registers, written with the pipe empty and the sequencer idle.
    task automatic configure(input logic [7:0] ticks, input logic [7:0] polls);
        drain_results();
        repeat (4) @(posedge aclk);  // two-stage pipe, plus margin
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PHASE_TICKS;
        cfg_data  <= ticks;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(CFG_PHASE_TICKS, ticks);
        cfg_index <= CFG_ACK_POLL_LIMIT;
        cfg_data  <= polls;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(CFG_ACK_POLL_LIMIT, polls);
        cfg_valid <= 1'b0;
    endtask

    // Issue a command and tick it through to idle.
    // flip_pct: chance per tick of a random SDA sample instead of the bus value.
    // junk_pct: chance per tick of a command beat thrown in while busy.
    task automatic run_command(input logic [2:0] kind, input logic [7:0] txb,
                               input int flip_pct, input int junk_pct);
        logic sda;
        send_item(kind, txb, 1'($urandom_range(0, 1)));
        if (!sb.is_idle())
            work_items++;
        while (!sb.is_idle()) begin
            if ($urandom_range(0, 99) < junk_pct)
                send_item(3'($urandom_range(KIND_START, KIND_RSVD7)), 8'($urandom),
                          1'($urandom_range(0, 1)));
            sda = ($urandom_range(0, 99) < flip_pct) ? 1'($urandom_range(0, 1)) : bus_sda();
            send_item(KIND_TICK, 8'($urandom), sda);
            work_items++;
        end
    endtask

    task automatic run_traffic(input int budget);
        int goal;
        int pick;
        bit broken;
        goal = work_items + budget;
        while (work_items < goal) begin
            pick = $urandom_range(0, 99);
            sc_busy_fault  = ($urandom_range(0, 7) == 0);
            sc_start_fault = ($urandom_range(0, 7) == 0);
            sc_ack_delay   = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                                          : $urandom_range(0, 300);
            sc_slave_byte  = 8'($urandom);
            if (pick < 5) begin
                // reserved kinds at idle: dropped
                send_item(($urandom_range(0, 1) != 0) ? KIND_RSVD7 : KIND_RSVD6,
                          8'($urandom), 1'($urandom_range(0, 1)));
            end else if (pick < 10) begin
                // idle tick: nothing moves
                send_item(KIND_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                broken = ($urandom_range(0, 4) == 0);
                run_command(3'($urandom_range(KIND_START, KIND_RD_NACK)), 8'($urandom),
                            broken ? 30 : 0, broken ? 10 : 2);
            end
            // no sender pauses in the closing stretch
            if (src_gaps && $urandom_range(0, 59) == 0)
                drain_results();
        end
    endtask

    initial begin : stimulus
        sb = new();
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_kind       <= KIND_TICK;
        s_tx_byte    <= 8'h00;
        s_sda_sample <= 1'b1;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_PHASE_TICKS;
        cfg_data     <= 8'h00;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed: zero-valued registers act as one ----
        configure(8'd0, 8'd0);
        // idle ticks and reserved kinds change nothing
        send_item(KIND_TICK, 8'h00, 1'b0);
        send_item(KIND_TICK, 8'hFF, 1'b1);
        send_item(KIND_RSVD6, 8'hFF, 1'b1);
        send_item(KIND_RSVD7, 8'h00, 1'b0);
        // start into a bus held low
        set_scenario(1'b1, 1'b0, 0, 8'h00);
        run_command(KIND_START, 8'h00, 0, 0);
        // start whose SDA never follows low
        set_scenario(1'b0, 1'b1, 0, 8'h00);
        run_command(KIND_START, 8'hFF, 0, 0);
        // clean start, commands while busy must be dropped
        set_scenario(1'b0, 1'b0, 0, 8'h00);
        run_command(KIND_START, 8'h00, 0, 100);
        // write all ones, ACK on first poll
        run_command(KIND_WRITE, 8'hFF, 0, 0);
        // write all zeros, slave never ACKs: timeout after one poll
        set_scenario(1'b0, 1'b0, 300, 8'h00);
        run_command(KIND_WRITE, 8'h00, 0, 0);
        // reads with both ACK modes and extreme data
        set_scenario(1'b0, 1'b0, 0, 8'hFF);
        run_command(KIND_RD_ACK, 8'h00, 0, 0);
        set_scenario(1'b0, 1'b0, 0, 8'h00);
        run_command(KIND_RD_NACK, 8'hFF, 0, 0);
        run_command(KIND_STOP, 8'h00, 0, 0);
        // sender waits out every outstanding beat at least once
        drain_results();

        // ---- random phases ----
        configure(8'd1, 8'd255);
        run_traffic(350);
        configure(8'($urandom_range(2, 4)), 8'($urandom_range(1, 20)));
        run_traffic(250);
        // longest phases: a single stop keeps the run short
        configure(8'd255, 8'd255);
        set_scenario(1'b0, 1'b0, 0, 8'h00);
        run_command(KIND_STOP, 8'($urandom), 0, 0);
        configure(8'd2, 8'd1);
        run_traffic(200);
        configure(8'd3, 8'd8);
        run_traffic(200);
        // closing stretch at full rate on both sides
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        configure(8'd1, 8'd2);
        run_traffic(150);

        drain_results();
        repeat (8) @(posedge aclk);
        sb.flush_check();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
